// ----- design/pid_filter_table_reconciler_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the PID filter table reconciler checker
// ---------------------------------------------------------------------------
`ifndef PID_FILTER_TABLE_RECONCILER_ASSERT_SVH
`define PID_FILTER_TABLE_RECONCILER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define PFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define PFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pfr_pkg.sv -----
// ---------------------------------------------------------------------------
// pfr_pkg
// Types and constants shared by the PID filter table reconciler.
// ---------------------------------------------------------------------------
package pfr_pkg;

  localparam int unsigned PID_W      = 13;
  localparam int unsigned SLOT_PID_W = 14;
  localparam int unsigned IN_PID_W   = 16;

  localparam logic [SLOT_PID_W-1:0] NO_PID    = 14'h3FFF;
  localparam logic [IN_PID_W-1:0]   PID_LIMIT = 16'h2000;

  // Results per query
  localparam int unsigned MAX_RES = 32;
  localparam int unsigned RES_W   = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    ST_INVALID,
    ST_ADD,
    ST_VALID,
    ST_DELETE
  } slot_status_e;

  typedef enum logic [1:0] {
    REQ_ENTRY,
    REQ_PLAY,
    REQ_SETUP,
    REQ_CLEAR
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_DELETE,
    KIND_NONE,
    KIND_ACK
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_CLEAR,
    S_ACK,
    S_COMMIT_A,
    S_COMMIT_B,
    S_EMIT_A,
    S_EMIT_B,
    S_NONE
  } state_e;

  // One slot of the table as it travels along the ring
  typedef struct packed {
    logic [SLOT_PID_W-1:0] pid;
    slot_status_e          status;
    logic                  seen;
    logic                  rpt;
  } slot_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic cmp;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    kind_e            kind;
    logic [PID_W-1:0] pid;
    logic             last;
    logic             changed;
    logic             fail;
  } result_t;

endpackage

// ----- design/pfr_if.sv -----
// ---------------------------------------------------------------------------
// pfr_in_if / pfr_out_if
// Valid/ready channels carrying requests into and results out of the block.
// ---------------------------------------------------------------------------
interface pfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] pid;
  logic        last_entry;

  modport source (output valid, req_type, pid, last_entry, input ready);
  modport sink   (input valid, req_type, pid, last_entry, output ready);
endinterface

interface pfr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] out_pid;
  logic        last_result;
  logic        pid_dirty;
  logic        add_failed;

  modport source (output valid, kind, out_pid, last_result, pid_dirty, add_failed,
                  input ready);
  modport sink   (input valid, kind, out_pid, last_result, pid_dirty, add_failed,
                  output ready);
endinterface

// ----- design/pfr_cell.sv -----
// ---------------------------------------------------------------------------
// pfr_cell
// One slot of the PID table: compares against the broadcast PID, clears,
// or takes its neighbor's slot when the ring shifts.
// ---------------------------------------------------------------------------
module pfr_cell import pfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [PID_W-1:0] cmp_pid_i,
  input  slot_t            next_i,
  output slot_t            slot_o,
  output logic             match_o
);

  slot_t slot_q, slot_d;

  assign match_o = (slot_q.pid == {1'b0, cmp_pid_i});
  assign slot_o  = slot_q;

  // Select shift, clear or match update
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.shift) begin
      slot_d = next_i;
    end else if (ctrl_i.clear) begin
      slot_d.status = ST_INVALID;
      slot_d.seen   = 1'b0;
      slot_d.rpt    = 1'b0;
    end else if (ctrl_i.cmp && match_o) begin
      slot_d.seen = 1'b1;
      case (slot_q.status)
        ST_INVALID: slot_d.status = ST_ADD;
        ST_DELETE:  slot_d.status = ST_VALID;
        default:    slot_d.status = slot_q.status;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.pid    <= NO_PID;
      slot_q.status <= ST_INVALID;
      slot_q.seen   <= 1'b0;
      slot_q.rpt    <= 1'b0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

// ----- design/pfr_ctrl.sv -----
// ---------------------------------------------------------------------------
// pfr_ctrl
// Sequencer at the head of the cell ring: rotates slots past the head logic
// to insert, run the delete pass, commit and report, and holds the result
// register.
// ---------------------------------------------------------------------------
module pfr_ctrl import pfr_pkg::*; #(
  parameter int unsigned PID_SLOTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [IN_PID_W-1:0]  req_pid_i,
  input  logic                 req_last_i,
  input  logic [PID_SLOTS-1:0] match_i,
  input  slot_t                head_i,
  output slot_t                tail_o,
  output cell_ctrl_t           cell_ctrl_o,
  output logic [PID_W-1:0]     cmp_pid_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output result_t              res_o
);

  localparam int unsigned CNT_W = (PID_SLOTS > 1) ? $clog2(PID_SLOTS) : 1;

  state_e            state_q, state_d;
  req_type_e         type_q, type_d;
  logic [PID_W-1:0]  pid_q, pid_d;
  logic              pid_ok_q, pid_ok_d;
  logic              last_q, last_d;
  logic              found_q, found_d;
  logic              ins_q, ins_d;
  logic              chg_q, chg_d;
  logic              fail_q, fail_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RES_W-1:0]  n_q, n_d;
  logic [RES_W-1:0]  rem_q, rem_d;
  logic              out_valid_q;
  result_t           out_q, out_d;
  logic              emit;
  logic              out_free;
  logic              cnt_last;
  logic              ins_go;
  logic              want;
  logic              room;
  slot_t             rec;

  assign out_free  = !out_valid_q || res_ready_i;
  assign cnt_last  = (cnt_q == CNT_W'(PID_SLOTS - 1));
  assign room      = (n_q < RES_W'(MAX_RES));
  assign cmp_pid_o = pid_q;

  // Next state, head slot rewrite and result load
  always_comb begin
    state_d     = state_q;
    type_d      = type_q;
    pid_d       = pid_q;
    pid_ok_d    = pid_ok_q;
    last_d      = last_q;
    found_d     = found_q;
    ins_d       = ins_q;
    chg_d       = chg_q;
    fail_d      = fail_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    rem_d       = rem_q;
    out_d       = out_q;
    emit        = 1'b0;
    req_ready_o = 1'b0;
    cell_ctrl_o = '0;
    rec         = head_i;
    ins_go      = 1'b0;
    want        = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          type_d   = req_type_e'(req_type_i);
          pid_d    = req_pid_i[PID_W-1:0];
          pid_ok_d = (req_pid_i < PID_LIMIT);
          last_d   = req_last_i;
          cnt_d    = '0;
          n_d      = '0;
          chg_d    = 1'b0;
          ins_d    = 1'b0;
          case (req_type_e'(req_type_i))
            REQ_ENTRY: state_d = S_MATCH;
            REQ_PLAY:  state_d = S_COMMIT_A;
            REQ_SETUP: state_d = S_COMMIT_A;
            REQ_CLEAR: state_d = S_CLEAR;
            default:   state_d = S_IDLE;
          endcase
        end
      end

      // Compare in every cell at once
      S_MATCH: begin
        cell_ctrl_o.cmp = pid_ok_q;
        found_d         = |match_i;
        state_d         = S_SCAN;
      end

      // Rotate once: insert into first free slot, then on the last entry the delete pass
      S_SCAN: begin
        cell_ctrl_o.shift = 1'b1;
        ins_go = pid_ok_q && !found_q && !ins_q && (head_i.status == ST_INVALID);
        if (ins_go) begin
          rec.pid    = {1'b0, pid_q};
          rec.status = ST_ADD;
          rec.seen   = 1'b1;
          ins_d      = 1'b1;
        end
        if (last_q) begin
          if (!rec.seen) begin
            case (rec.status)
              ST_ADD:   rec.status = ST_INVALID;
              ST_VALID: rec.status = ST_DELETE;
              default:  rec.status = rec.status;
            endcase
          end
          rec.seen = 1'b0;
        end
        chg_d = chg_q | (rec.status == ST_ADD) | (rec.status == ST_DELETE);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          fail_d  = pid_ok_q && !found_q && !ins_q && !ins_go;
          state_d = S_ACK;
        end
      end

      S_CLEAR: begin
        cell_ctrl_o.clear = 1'b1;
        chg_d   = 1'b0;
        fail_d  = 1'b0;
        state_d = S_ACK;
      end

      S_ACK: begin
        if (out_free) begin
          emit          = 1'b1;
          out_d.kind    = KIND_ACK;
          out_d.pid     = '0;
          out_d.last    = 1'b1;
          out_d.changed = chg_q;
          out_d.fail    = fail_q;
          state_d       = S_IDLE;
        end
      end

      // Commit adds (play) or all active slots (setup)
      S_COMMIT_A: begin
        cell_ctrl_o.shift = 1'b1;
        if (room && ((head_i.status == ST_ADD) ||
                     ((type_q == REQ_SETUP) && (head_i.status == ST_VALID)))) begin
          rec.status = ST_VALID;
          rec.rpt    = 1'b1;
          n_d        = n_q + RES_W'(1);
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_COMMIT_B;
        end
      end

      // Commit deletes (play) and collect the changed flag
      S_COMMIT_B: begin
        cell_ctrl_o.shift = 1'b1;
        if (room && (type_q == REQ_PLAY) && (head_i.status == ST_DELETE)) begin
          rec.status = ST_INVALID;
          rec.rpt    = 1'b1;
          n_d        = n_q + RES_W'(1);
        end
        chg_d = chg_q | (rec.status == ST_ADD) | (rec.status == ST_DELETE);
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          rem_d   = n_d;
          state_d = (n_d == '0) ? S_NONE : S_EMIT_A;
        end
      end

      // Report marked slots: adds on the first turn, deletes on the second
      S_EMIT_A, S_EMIT_B: begin
        want = head_i.rpt &&
               (head_i.status == ((state_q == S_EMIT_A) ? ST_VALID : ST_INVALID));
        if (!want || out_free) begin
          cell_ctrl_o.shift = 1'b1;
          if (want) begin
            emit          = 1'b1;
            rec.rpt       = 1'b0;
            out_d.kind    = (state_q == S_EMIT_A) ? KIND_ADD : KIND_DELETE;
            out_d.pid     = head_i.pid[PID_W-1:0];
            out_d.last    = (rem_q == RES_W'(1));
            out_d.changed = chg_q;
            out_d.fail    = 1'b0;
            rem_d         = rem_q - RES_W'(1);
          end
          cnt_d = cnt_q + CNT_W'(1);
          if (cnt_last) begin
            cnt_d   = '0;
            state_d = (state_q == S_EMIT_A) ? S_EMIT_B : S_IDLE;
          end
        end
      end

      S_NONE: begin
        if (out_free) begin
          emit          = 1'b1;
          out_d.kind    = KIND_NONE;
          out_d.pid     = '0;
          out_d.last    = 1'b1;
          out_d.changed = chg_q;
          out_d.fail    = 1'b0;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign tail_o      = rec;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      n_q         <= '0;
      rem_q       <= '0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      rem_q       <= rem_d;
      ins_q       <= ins_d;
      out_valid_q <= emit ? 1'b1 : (res_ready_i ? 1'b0 : out_valid_q);
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    type_q   <= type_d;
    pid_q    <= pid_d;
    pid_ok_q <= pid_ok_d;
    last_q   <= last_d;
    found_q  <= found_d;
    chg_q    <= chg_d;
    fail_q   <= fail_d;
    out_q    <= out_d;
  end

endmodule

// ----- design/pid_filter_table_reconciler.sv -----
// Results: a query reports at most one result a cycle once reporting starts.
// Throughput: one request at a time; the slot ring turns past the head logic
// once per list entry, four times (plus output stalls) per query that reports
// and twice per query with nothing to report.
// Reset (async, rst_ni low): slots invalid with no PID, sequencer idle, no result.
// ---------------------------------------------------------------------------
// pid_filter_table_reconciler
// PID slot table kept in a ring of cells, reconciled against a requested
// PID list and queried for pending changes or all active PIDs.
// ---------------------------------------------------------------------------
module pid_filter_table_reconciler import pfr_pkg::*; #(
  parameter int unsigned PID_SLOTS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfr_in_if.sink    in_i,
  pfr_out_if.source out_o
);

  slot_t                slots [PID_SLOTS];
  logic [PID_SLOTS-1:0] match;
  slot_t                tail;
  cell_ctrl_t           cell_ctrl;
  logic [PID_W-1:0]     cmp_pid;
  result_t              res;

  // Ring of slot cells, slot 0 at the head
  for (genvar i = 0; i < PID_SLOTS; i++) begin : g_cell
    slot_t next;
    if (i == PID_SLOTS - 1) begin : g_tail
      assign next = tail;
    end else begin : g_mid
      assign next = slots[i+1];
    end
    pfr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .cmp_pid_i (cmp_pid),
      .next_i    (next),
      .slot_o    (slots[i]),
      .match_o   (match[i])
    );
  end

  pfr_ctrl #(
    .PID_SLOTS (PID_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_type_i  (in_i.req_type),
    .req_pid_i   (in_i.pid),
    .req_last_i  (in_i.last_entry),
    .match_i     (match),
    .head_i      (slots[0]),
    .tail_o      (tail),
    .cell_ctrl_o (cell_ctrl),
    .cmp_pid_o   (cmp_pid),
    .res_valid_o (out_o.valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  // Drive the result channel
  assign out_o.kind        = res.kind;
  assign out_o.out_pid     = res.pid;
  assign out_o.last_result = res.last;
  assign out_o.pid_dirty   = res.changed;
  assign out_o.add_failed  = res.fail;

endmodule

// ----- design/pfr_checker.sv -----
// ---------------------------------------------------------------------------
// pfr_checker
// Port-level checks on the reconciler, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "pid_filter_table_reconciler_assert.svh"

module pfr_checker import pfr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [12:0] out_pid_i,
  input logic        out_last_i,
  input logic        out_fail_i
);

  // Hold a stalled result
  `PFR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result lost under stall")
  // Refuse requests while a result burst is unfinished
  `PFR_ASSERT_NOW(a_busy_burst, out_valid_i && !out_last_i, !in_ready_i, "request taken mid burst")
  // Go busy after taking a request
  `PFR_ASSERT_NEXT(a_busy_after, in_valid_i && in_ready_i, !in_ready_i, "ready held after request")
  // Flag a failed add only on an acknowledge
  `PFR_ASSERT_NOW(a_fail_ack, out_valid_i && out_fail_i, out_kind_i == KIND_ACK, "add_failed on report")
  // Close single results with last set and no PID
  `PFR_ASSERT_NOW(a_single, out_valid_i && (out_kind_i == KIND_NONE || out_kind_i == KIND_ACK), out_last_i && out_pid_i == '0, "bad single result")

endmodule

bind pid_filter_table_reconciler pfr_checker u_pfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_pid_i   (out_o.out_pid),
  .out_last_i  (out_o.last_result),
  .out_fail_i  (out_o.add_failed)
);
